### hw/rtl/esp_pkg.sv
`timescale 1ns / 1ps
package esp_pkg;
    localparam int COUNT_WIDTH = 16;
    localparam int COORD_W     = 32;
    localparam int ROOT_W      = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DIVN,
        ST_DIVS,
        ST_CHECK,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] segment_count;
        logic                   error_code;
        logic [30:0]            subdivided_edges;
        logic [31:0]            inserted_vertices;
        logic [COUNT_WIDTH-1:0] max_segments;
        logic [31:0]            max_segment_length;
        logic [30:0]            invalid_plans;
        logic [30:0]            total_segments;
        logic [30:0]            edge_count;
    } result_t;

    typedef struct packed {
        logic                     first_edge;
        logic signed [31:0]       start_x;
        logic signed [31:0]       start_y;
        logic signed [31:0]       start_z;
        logic signed [31:0]       end_x;
        logic signed [31:0]       end_y;
        logic signed [31:0]       end_z;
        logic [31:0]              target_start;
        logic [31:0]              target_end;
    } edge_t;
endpackage

### hw/rtl/esp_if.sv
`timescale 1ns / 1ps
interface esp_edge_if;
    logic          valid;
    logic          ready;
    esp_pkg::edge_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface esp_result_if;
    logic            valid;
    logic            ready;
    esp_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/edge_subdivision_planner.sv
`timescale 1ns / 1ps
// Channel     Dir  Payload
// edge_in     in   esp_pkg::edge_t   (valid/ready)
// result_out  out  esp_pkg::result_t (valid/ready)
// cfg         in   split_ratio write (cfg_we/cfg_wdata)
//
// One edge runs through three squares by a shift-add multiplier, a 33-step
// bit-pair square root, then three passes of a shared 64-step restoring
// divider: segment count, segment length, tolerance check. A zero split ratio
// skips the count and check divisions; zero targets go straight to the result.
// Reset clears statistics and control. An edge is taken whenever the engine is
// idle, also while the previous result waits; a finished edge holds in its
// last state until the result register is free.
module edge_subdivision_planner
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    esp_edge_if.sink            edge_in,
    esp_result_if.source        result_out
);
    localparam logic [esp_pkg::COUNT_WIDTH-1:0] NMAX = '1;
    localparam logic [esp_pkg::COUNT_WIDTH-1:0] ONE_SEG =
        {{(esp_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

    esp_pkg::state_t state_reg, state_next;
    logic [15:0]  ratio_reg;
    esp_pkg::edge_t e_reg;
    logic [32:0]  h2_reg;
    logic [1:0]   axis_reg;
    logic [5:0]   step_reg;
    logic [31:0]  mcand_reg;
    logic [31:0]  mplier_reg;
    logic [65:0]  sum_reg;
    logic [32:0]  root_reg;
    logic [35:0]  rem_reg;
    logic [48:0]  den_reg;
    logic [esp_pkg::COUNT_WIDTH-1:0] n_reg;
    logic [1:0]   pass_reg;
    logic         bad_reg;
    logic [31:0]  seg_reg;
    logic         busy_reg;
    esp_pkg::result_t res_reg;
    logic         res_valid_reg;

    logic [30:0]  sub_reg, inv_reg, segt_reg, edges_reg;
    logic [31:0]  ins_reg, lmax_reg;
    logic [esp_pkg::COUNT_WIDTH-1:0] cmax_reg;

    logic         div_start;
    logic [63:0]  div_dividend;
    logic         div_done;
    logic [63:0]  div_q;
    logic [49:0]  div_r;

    logic         take;
    logic         res_free;
    logic [32:0]  diff;
    logic [31:0]  absd;
    logic [35:0]  trial;
    logic [35:0]  rem_sh;
    logic [41:0]  num;
    logic [66:0]  kval;

    assign take = edge_in.valid && edge_in.ready;
    assign edge_in.ready = !busy_reg;
    assign res_free = !res_valid_reg || result_out.ready;
    assign num = {root_reg, 9'd0};
    assign kval = 67'(n_reg) * 67'd131073;

    // Select absolute difference of the current axis
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    diff = {e_reg.start_x[31], e_reg.start_x} - {e_reg.end_x[31], e_reg.end_x};
            2'd1:    diff = {e_reg.start_y[31], e_reg.start_y} - {e_reg.end_y[31], e_reg.end_y};
            default: diff = {e_reg.start_z[31], e_reg.start_z} - {e_reg.end_z[31], e_reg.end_z};
        endcase
        absd = diff[32] ? 32'(-diff) : diff[31:0];
    end

    // Root step on the next bit pair
    always_comb
    begin
        rem_sh = {rem_reg[33:0], sum_reg[65:64]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    // Divider operand by pass
    always_comb
    begin
        unique case (pass_reg)
            2'd0:    div_dividend = 64'(num) + 64'(den_reg) - 64'd1;
            2'd1:    div_dividend = 64'(root_reg);
            default: div_dividend = {5'd0, num, 17'd0};
        endcase
    end

    esp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((pass_reg == 2'd1) ? 49'(n_reg) : den_reg),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            esp_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = esp_pkg::ST_SQ;
                end
            end
            esp_pkg::ST_SQ:
            begin
                if (h2_reg == '0)
                begin
                    state_next = esp_pkg::ST_OUT;
                end
                else if (axis_reg == 2'd2 && step_reg == 6'd32)
                begin
                    state_next = esp_pkg::ST_ROOT;
                end
            end
            esp_pkg::ST_ROOT:
            begin
                if (step_reg == 6'd32)
                begin
                    state_next = esp_pkg::ST_DIVN;
                end
            end
            esp_pkg::ST_DIVN:
            begin
                if (den_reg == '0)
                begin
                    state_next = esp_pkg::ST_DIVS;
                end
                else if (step_reg == 6'd0)
                begin
                    div_start = 1'b1;
                end
                else if (div_done)
                begin
                    state_next = esp_pkg::ST_DIVS;
                end
            end
            esp_pkg::ST_DIVS:
            begin
                if (step_reg == 6'd0)
                begin
                    div_start = 1'b1;
                end
                else if (div_done)
                begin
                    state_next = (den_reg == '0) ? esp_pkg::ST_UPDATE : esp_pkg::ST_CHECK;
                end
            end
            esp_pkg::ST_CHECK:
            begin
                if (step_reg == 6'd0)
                begin
                    div_start = 1'b1;
                end
                else if (div_done)
                begin
                    state_next = esp_pkg::ST_UPDATE;
                end
            end
            esp_pkg::ST_UPDATE:
            begin
                state_next = esp_pkg::ST_OUT;
            end
            esp_pkg::ST_OUT:
            begin
                if (res_free)
                begin
                    state_next = esp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = esp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= 16'd341;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            e_reg         <= '0;
            h2_reg        <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            sum_reg       <= '0;
            root_reg      <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            n_reg         <= '0;
            bad_reg       <= 1'b0;
            seg_reg       <= '0;
            sub_reg       <= '0;
            inv_reg       <= '0;
            segt_reg      <= '0;
            edges_reg     <= '0;
            ins_reg       <= '0;
            lmax_reg      <= '0;
            cmax_reg      <= '0;
            step_reg      <= '0;
            axis_reg      <= '0;
            pass_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ratio_reg <= cfg_wdata;
            end
            // Raise the result flag on a finished edge, drop it when taken
            if (state_reg == esp_pkg::ST_OUT && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_out.valid && result_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                esp_pkg::ST_IDLE:
                begin
                    if (take)
                    begin
                        busy_reg  <= 1'b1;
                        e_reg     <= edge_in.data;
                        h2_reg    <= {1'b0, edge_in.data.target_start}
                                     + {1'b0, edge_in.data.target_end};
                        axis_reg  <= '0;
                        step_reg  <= '0;
                        sum_reg   <= '0;
                        bad_reg   <= 1'b0;
                        pass_reg  <= 2'd0;
                        if (edge_in.data.first_edge)
                        begin
                            sub_reg   <= '0;
                            inv_reg   <= '0;
                            segt_reg  <= '0;
                            edges_reg <= '0;
                            ins_reg   <= '0;
                            lmax_reg  <= '0;
                            cmax_reg  <= '0;
                        end
                    end
                end
                esp_pkg::ST_SQ:
                begin
                    den_reg <= 49'(ratio_reg) * 49'(h2_reg);
                    // Shift-add square, one multiplier bit per cycle
                    if (step_reg == 6'd0)
                    begin
                        mcand_reg  <= absd;
                        mplier_reg <= absd;
                        step_reg   <= 6'd1;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            sum_reg <= sum_reg
                                       + (66'(mcand_reg) << (step_reg - 6'd1));
                        end
                        mplier_reg <= mplier_reg >> 1;
                        if (step_reg == 6'd32)
                        begin
                            step_reg <= '0;
                            axis_reg <= axis_reg + 2'd1;
                            root_reg <= '0;
                            rem_reg  <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 6'd1;
                        end
                    end
                end
                esp_pkg::ST_ROOT:
                begin
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[31:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[31:0], 1'b0};
                    end
                    sum_reg  <= {sum_reg[63:0], 2'b00};
                    step_reg <= (step_reg == 6'd32) ? 6'd0 : step_reg + 6'd1;
                end
                esp_pkg::ST_DIVN:
                begin
                    if (den_reg == '0)
                    begin
                        n_reg    <= (root_reg != '0) ? NMAX : ONE_SEG;
                        bad_reg  <= (root_reg != '0);
                        pass_reg <= 2'd1;
                        step_reg <= '0;
                    end
                    else if (step_reg == 6'd0)
                    begin
                        step_reg <= 6'd1;
                    end
                    else if (div_done)
                    begin
                        if (div_q > 64'(NMAX))
                        begin
                            n_reg <= NMAX;
                        end
                        else if (div_q == '0)
                        begin
                            n_reg <= ONE_SEG;
                        end
                        else
                        begin
                            n_reg <= div_q[esp_pkg::COUNT_WIDTH-1:0];
                        end
                        pass_reg <= 2'd1;
                        step_reg <= '0;
                    end
                end
                esp_pkg::ST_DIVS:
                begin
                    if (step_reg == 6'd0)
                    begin
                        step_reg <= 6'd1;
                    end
                    else if (div_done)
                    begin
                        seg_reg  <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
                        pass_reg <= 2'd2;
                        step_reg <= '0;
                    end
                end
                esp_pkg::ST_CHECK:
                begin
                    if (step_reg == 6'd0)
                    begin
                        step_reg <= 6'd1;
                    end
                    else if (div_done)
                    begin
                        bad_reg <= (67'(div_q) > kval)
                                   || ((67'(div_q) == kval) && (div_r != '0));
                    end
                end
                esp_pkg::ST_UPDATE:
                begin
                    // Fold this edge into the statistics
                    if (n_reg > ONE_SEG)
                    begin
                        sub_reg <= (sub_reg == '1) ? sub_reg : sub_reg + 31'd1;
                        ins_reg <= (33'(ins_reg) + 33'(n_reg) - 33'd1 > 33'hFFFF_FFFF)
                                   ? 32'hFFFF_FFFF : ins_reg + 32'(n_reg) - 32'd1;
                    end
                    if (n_reg > cmax_reg)
                    begin
                        cmax_reg <= n_reg;
                    end
                    if (seg_reg > lmax_reg)
                    begin
                        lmax_reg <= seg_reg;
                    end
                    if (bad_reg)
                    begin
                        inv_reg <= (inv_reg == '1) ? inv_reg : inv_reg + 31'd1;
                    end
                    segt_reg  <= (32'(segt_reg) + 32'(n_reg) > 32'h7FFF_FFFF)
                                 ? 31'h7FFF_FFFF : segt_reg + 31'(n_reg);
                    edges_reg <= (edges_reg == '1) ? edges_reg : edges_reg + 31'd1;
                end
                esp_pkg::ST_OUT:
                begin
                    // Hold until the result register is free
                    if (res_free)
                    begin
                        busy_reg <= 1'b0;
                        res_reg.segment_count      <= (h2_reg == '0) ? '0 : n_reg;
                        res_reg.error_code         <= (h2_reg == '0);
                        res_reg.subdivided_edges   <= sub_reg;
                        res_reg.inserted_vertices  <= ins_reg;
                        res_reg.max_segments       <= cmax_reg;
                        res_reg.max_segment_length <= lmax_reg;
                        res_reg.invalid_plans      <= inv_reg;
                        res_reg.total_segments     <= segt_reg;
                        res_reg.edge_count         <= edges_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_out.valid = res_valid_reg;
    assign result_out.data  = res_reg;

    // A waiting result holds its data until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result_out.ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result changed while waiting");
    // Input is only taken when idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == esp_pkg::ST_IDLE))
        else $error("edge taken while busy");
    // Error result carries a zero count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.error_code) |-> (res_reg.segment_count == '0))
        else $error("error result with nonzero count");
endmodule

### hw/rtl/esp_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. 64-bit dividend, 49-bit divisor.
module esp_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [48:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [49:0] remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [49:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [50:0] shifted;
    logic [50:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {2'b00, divisor};

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[50])
            begin
                rem_next = diff[49:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[49:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 7'd1);
    assign quotient  = quo_next;
    assign remainder = rem_next;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps

class plan_scoreboard;
    // Planner state copy
    bit [15:0] split_ratio;
    bit [30:0] subdivided_total;
    bit [31:0] inserted_total;
    bit [15:0] largest_count;
    bit [31:0] largest_length;
    bit [30:0] invalid_total;
    bit [30:0] segment_total;
    bit [30:0] edges_seen;
    esp_pkg::result_t pending_plans[$];
    int        mismatches;

    function void clear_stats();
        subdivided_total = 0;
        inserted_total = 0;
        largest_count = 0;
        largest_length = 0;
        invalid_total = 0;
        segment_total = 0;
        edges_seen = 0;
    endfunction

    function void reset_state();
        split_ratio = 16'd341;
        clear_stats();
        pending_plans.delete();
    endfunction

    function bit [32:0] edge_length(esp_pkg::edge_t e);
        bit [32:0] dx;
        bit [32:0] dy;
        bit [32:0] dz;
        bit [67:0] sum;
        bit [67:0] rem;
        bit [67:0] trial;
        bit [33:0] root;
        longint    d;
        d = longint'(e.start_x) - longint'(e.end_x);
        dx = 33'(d < 0 ? -d : d);
        d = longint'(e.start_y) - longint'(e.end_y);
        dy = 33'(d < 0 ? -d : d);
        d = longint'(e.start_z) - longint'(e.end_z);
        dz = 33'(d < 0 ? -d : d);
        sum = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
        root = 0;
        rem = 0;
        for (int i = 33; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'((sum >> (2 * i)) & 68'd3);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    // Note an accepted request and queue its expected plan
    function void note_edge(esp_pkg::edge_t e);
        esp_pkg::result_t r;
        bit [32:0] h2;
        bit [32:0] len;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        bit [63:0] n;
        bit [63:0] seg;
        bit [63:0] x;
        bit [63:0] k;
        bit [63:0] fq;
        bit        bad;
        if (e.first_edge)
            clear_stats();
        h2 = 33'(e.target_start) + 33'(e.target_end);
        r = '0;
        if (h2 == 0)
            r.error_code = 1'b1;
        else
        begin
            len = edge_length(e);
            num = 64'(len) << 9;
            den = 64'(split_ratio) * 64'(h2);
            if (den == 0)
                n = len > 0 ? 64'd65535 : 64'd1;
            else
            begin
                q = (num + den - 1) / den;
                n = q > 65535 ? 64'd65535 : q;
                if (n < 1)
                    n = 1;
            end
            if (n > 1)
            begin
                if (subdivided_total != 31'h7FFFFFFF)
                    subdivided_total++;
                inserted_total = (64'(inserted_total) + n - 1 > 64'hFFFFFFFF)
                    ? 32'hFFFFFFFF : 32'(64'(inserted_total) + n - 1);
            end
            if (n > largest_count)
                largest_count = 16'(n);
            seg = 64'(len) / n;
            if (seg > 64'hFFFFFFFF)
                seg = 64'hFFFFFFFF;
            if (seg > largest_length)
                largest_length = 32'(seg);
            if (den == 0)
                bad = len > 0;
            else
            begin
                x = num << 17;
                k = ((64'd1 << 17) + 1) * n;
                fq = x / den;
                bad = (fq > k) || (fq == k && (x % den) != 0);
            end
            if (bad && invalid_total != 31'h7FFFFFFF)
                invalid_total++;
            segment_total = (64'(segment_total) + n > 64'h7FFFFFFF)
                ? 31'h7FFFFFFF : 31'(64'(segment_total) + n);
            if (edges_seen != 31'h7FFFFFFF)
                edges_seen++;
            r.segment_count = 16'(n);
        end
        r.subdivided_edges = subdivided_total;
        r.inserted_vertices = inserted_total;
        r.max_segments = largest_count;
        r.max_segment_length = largest_length;
        r.invalid_plans = invalid_total;
        r.total_segments = segment_total;
        r.edge_count = edges_seen;
        pending_plans = {pending_plans, r};
    endfunction

    task report(string what, longint got, longint want);
        $display("plan mismatch on %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // Compare a delivered plan with the oldest pending one
    task check_plan(esp_pkg::result_t got);
        esp_pkg::result_t want;
        if (pending_plans.size() == 0)
        begin
            report("unexpected plan", 1, 0);
            return;
        end
        want = pending_plans.pop_front();
        if (got.segment_count != want.segment_count)
            report("segment_count", got.segment_count, want.segment_count);
        if (got.error_code != want.error_code)
            report("error_code", got.error_code, want.error_code);
        if (got.subdivided_edges != want.subdivided_edges)
            report("subdivided_edges", got.subdivided_edges, want.subdivided_edges);
        if (got.inserted_vertices != want.inserted_vertices)
            report("inserted_vertices", got.inserted_vertices, want.inserted_vertices);
        if (got.max_segments != want.max_segments)
            report("max_segments", got.max_segments, want.max_segments);
        if (got.max_segment_length != want.max_segment_length)
            report("max_segment_length", got.max_segment_length,
                   want.max_segment_length);
        if (got.invalid_plans != want.invalid_plans)
            report("invalid_plans", got.invalid_plans, want.invalid_plans);
        if (got.total_segments != want.total_segments)
            report("total_segments", got.total_segments, want.total_segments);
        if (got.edge_count != want.edge_count)
            report("edge_count", got.edge_count, want.edge_count);
    endtask
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          stall_count;
    bit          run_done;

    esp_edge_if   edge_in();
    esp_result_if result_out();
    plan_scoreboard plans;

    edge_subdivision_planner DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .edge_in    (edge_in),
        .result_out (result_out)
    );

    always #5 clk = ~clk;

    // Send one request, waiting out the handshake; valid stays up afterwards
    task automatic send_edge(esp_pkg::edge_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            edge_in.valid <= 1'b0;
            @(posedge clk);
        end
        edge_in.valid <= 1'b1;
        edge_in.data <= e;
        @(posedge clk);
        while (!edge_in.ready)
            @(posedge clk);
        plans.note_edge(e);
    endtask

    // Drop valid and wait until every expected plan has come
    task automatic drain();
        edge_in.valid <= 1'b0;
        while (plans.pending_plans.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_ratio(bit [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        plans.split_ratio = v;
    endtask

    function automatic bit [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
            default: return 32'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    function automatic esp_pkg::edge_t random_edge();
        esp_pkg::edge_t e;
        int    kind;
        kind = $urandom_range(3);
        e.first_edge = ($urandom_range(19) == 0);
        e.start_x = rand_coord(kind);
        e.start_y = rand_coord(kind);
        e.start_z = rand_coord(kind);
        e.end_x = rand_coord(kind);
        e.end_y = rand_coord(kind);
        e.end_z = rand_coord(kind);
        case ($urandom_range(4))
            0:
            begin
                e.target_start = $urandom;
                e.target_end = $urandom;
            end
            1:
            begin
                e.target_start = 0;
                e.target_end = 0;
            end
            2:
            begin
                e.target_start = $urandom_range(255);
                e.target_end = 0;
            end
            default:
            begin
                e.target_start = $urandom_range(32'h40000);
                e.target_end = $urandom_range(32'h40000);
            end
        endcase
        return e;
    endfunction

    function automatic esp_pkg::edge_t make_edge(bit f, bit [31:0] sx, bit [31:0] ex,
                                                 bit [31:0] ts, bit [31:0] te);
        esp_pkg::edge_t e;
        e = '0;
        e.first_edge = f;
        e.start_x = sx;
        e.end_x = ex;
        e.start_y = sx;
        e.end_y = ex;
        e.target_start = ts;
        e.target_end = te;
        return e;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_edge(random_edge());
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_out.ready <= 1'b0;
        end
        else
            result_out.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && result_out.valid && result_out.ready)
            plans.check_plan(result_out.data);
    end

    // Watchdog on cycles with no accepted request or plan
    always @(posedge clk)
    begin
        if ((edge_in.valid && edge_in.ready) || (result_out.valid && result_out.ready)
            || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT && !run_done)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        plans = new();
        plans.reset_state();
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        edge_in.valid = 0;
        edge_in.data = '0;
        result_out.ready = 0;
        hold_cycles = 0;
        stall_count = 0;
        run_done = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, zero targets, clears
        send_edge(make_edge(1, 0, 0, 32'h10000, 32'h10000));
        send_edge(make_edge(0, 32'h80000000, 32'h7FFFFFFF, 32'h10000, 0));
        send_edge(make_edge(0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_edge(make_edge(0, 32'h12345, 32'h0, 0, 0));
        send_edge(make_edge(1, 32'h1000, 32'hFFFF0000, 0, 0));
        send_edge(make_edge(0, 32'h80000000, 32'h7FFFFFFF, 1, 0));
        send_edge(make_edge(0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1));
        send_edge(make_edge(0, 32'h30000, 32'h0, 32'h10000, 32'h10000));
        send_edge(make_edge(1, 32'h0, 32'h55555, 32'h8000, 32'h8000));
        drain();

        // Zero split ratio, then the largest
        write_ratio(16'd0);
        send_edge(make_edge(0, 0, 0, 32'h10000, 32'h10000));
        send_edge(make_edge(0, 32'h100, 0, 32'h10000, 32'h10000));
        send_edge(make_edge(0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        drain();
        write_ratio(16'hFFFF);
        send_edge(make_edge(0, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h0));
        send_edge(make_edge(0, 32'h123456, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF));
        drain();
        write_ratio(16'd1);

        // Fill up: long receiver hold-off while requests keep coming
        hold_cycles = 2000;
        run_random(6);
        drain();

        // Random phases
        send_idle_pct = 15;
        recv_idle_pct = 51;
        run_random(200);
        drain();
        write_ratio(16'd341);
        send_idle_pct = 51;
        recv_idle_pct = 15;
        run_random(200);
        drain();
        write_ratio(16'($urandom_range(1, 65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(200);
        drain();

        run_done = 1;
        if (plans.mismatches == 0 && plans.pending_plans.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
hw/rtl/esp_pkg.sv
hw/rtl/esp_if.sv
hw/rtl/esp_divider.sv
hw/rtl/edge_subdivision_planner.sv
bench/tb.sv
